[sv/fqd_pkg.sv]
package fqd_pkg;

    localparam int MAX_RES = 5;
    localparam int CNT_W   = 3;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] KIND_KEY     = 2'd0;
    localparam logic [1:0] KIND_VALUE   = 2'd1;
    localparam logic [1:0] KIND_COMMIT  = 2'd2;
    localparam logic [1:0] KIND_DISCARD = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } fqd_in_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic       array_key;
        logic       end_of_run;
    } fqd_out_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [CNT_W-1:0]             cnt;
        fqd_out_t [MAX_RES-1:0]       res;
    } fqd_bundle_t;

    // {valid, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [7:0] plain_byte(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    function automatic fqd_out_t make_out(input logic [1:0] kind, input logic [7:0] b,
                                          input logic arr);
        fqd_out_t o;
        o.out_kind   = kind;
        o.out_byte   = b;
        o.array_key  = arr;
        o.end_of_run = 1'b0;
        return o;
    endfunction

endpackage

[sv/form_query_decoder.sv]
// channel   direction  payload       handshake
// byte      in         fqd_in_t      byte_valid / byte_stall
// result    out        fqd_out_t     result_valid / result_stall
//
// one byte a cycle is taken while the bundle queue has room
// a byte's results (up to five) leave one per cycle from the back end
// while result_stall is low; bursts fill the queue
// byte_stall rises only when the queue (QUEUE_DEPTH bundles) is full
// reset: parser returns to key phase with no open escape, queue empties
module form_query_decoder
    import fqd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_stall,
    input  fqd_in_t  byte_data,
    output logic     result_valid,
    input  logic     result_stall,
    output fqd_out_t result_data
);

    logic        accept, push, full, pop, nonempty;
    fqd_bundle_t push_data, pop_data;

    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    fqd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .data   (byte_data),
        .push   (push),
        .bundle (push_data)
    );

    fqd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .nonempty  (nonempty),
        .pop_data  (pop_data)
    );

    fqd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .nonempty     (nonempty),
        .pop_data     (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("bundle pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("bundle popped from empty queue");

    // results of one byte leave without gaps
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !result_data.end_of_run) |=> result_valid)
        else $error("gap inside a result run");

    a_marker_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_data.out_kind == KIND_COMMIT
                          || result_data.out_kind == KIND_DISCARD))
        |-> (result_data.out_byte == 8'd0))
        else $error("pair marker carries a byte");

endmodule

[sv/fqd_front.sv]
module fqd_front
    import fqd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  fqd_in_t     data,
    output logic        push,
    output fqd_bundle_t bundle
);

    typedef enum logic [1:0] {ESC_IDLE, ESC_HI, ESC_LO} esc_t;

    esc_t       esc_reg, esc_next;
    logic       ivp_reg, ivp_next;
    logic [3:0] hn_reg, hn_next;
    logic [1:0] kl_reg, kl_next;
    logic [7:0] h0_reg, h0_next;
    logic [7:0] h1_reg, h1_next;

    logic [CNT_W-1:0] n;
    fqd_out_t [MAX_RES-1:0] res;
    logic [4:0] hx;
    logic [1:0] nd;
    logic [7:0] d0, d1, b, c;
    logic       arr;

    always_comb
    begin
        c        = data.in_byte;
        ivp_next = ivp_reg;
        esc_next = esc_reg;
        hn_next  = hn_reg;
        kl_next  = kl_reg;
        h0_next  = h0_reg;
        h1_next  = h1_reg;
        n        = '0;
        res      = '0;
        nd       = 2'd0;
        d0       = 8'd0;
        d1       = 8'd0;
        b        = 8'd0;
        hx       = hex_decode(c);
        arr      = 1'b0;

        if (!ivp_next && c == CH_EQ) begin
            arr = (kl_next == 2'd3) && (h0_next == CH_LBR) && (h1_next == CH_RBR);
            if (!arr) begin
                if (kl_next != 2'd0) begin
                    res[n] = make_out(KIND_KEY, h0_next, 1'b0);
                    n      = n + 3'd1;
                end
                if (kl_next[1]) begin
                    res[n] = make_out(KIND_KEY, h1_next, 1'b0);
                    n      = n + 3'd1;
                end
            end
            ivp_next = 1'b1;
        end else if (c == CH_AMP) begin
            arr = (kl_next == 2'd3) && (h0_next == CH_LBR) && (h1_next == CH_RBR);
            if (!ivp_next && !arr) begin
                if (kl_next != 2'd0) begin
                    res[n] = make_out(KIND_KEY, h0_next, 1'b0);
                    n      = n + 3'd1;
                end
                if (kl_next[1]) begin
                    res[n] = make_out(KIND_KEY, h1_next, 1'b0);
                    n      = n + 3'd1;
                end
            end
            res[n]   = make_out(KIND_COMMIT, 8'd0, arr);
            n        = n + 3'd1;
            ivp_next = 1'b0;
            kl_next  = 2'd0;
        end else if (c == CH_PCT) begin
            esc_next = ESC_HI;
        end else begin
            case (esc_next)
                ESC_HI:
                begin
                    if (!hx[4]) begin
                        esc_next = ESC_IDLE;
                        d0       = plain_byte(c);
                        nd       = 2'd1;
                    end else begin
                        hn_next  = hx[3:0];
                        esc_next = ESC_LO;
                    end
                end
                ESC_LO:
                begin
                    esc_next = ESC_IDLE;
                    if (!hx[4]) begin
                        // bad low digit: high nibble alone, then the byte itself
                        d0 = {hn_next, 4'd0};
                        d1 = plain_byte(c);
                        nd = 2'd2;
                    end else begin
                        d0 = {hn_next, hx[3:0]};
                        nd = 2'd1;
                    end
                end
                default:
                begin
                    d0 = plain_byte(c);
                    nd = 2'd1;
                end
            endcase
        end

        // key bytes go through a two-deep hold line so a trailing [] can be dropped
        for (int i = 0; i < 2; i++) begin
            if (2'(i) < nd) begin
                b = (i == 0) ? d0 : d1;
                if (ivp_next) begin
                    res[n] = make_out(KIND_VALUE, b, 1'b0);
                    n      = n + 3'd1;
                end else begin
                    if (kl_next[1]) begin
                        res[n]  = make_out(KIND_KEY, h0_next, 1'b0);
                        n       = n + 3'd1;
                        h0_next = h1_next;
                        h1_next = b;
                    end else if (kl_next == 2'd1) begin
                        h1_next = b;
                    end else begin
                        h0_next = b;
                    end
                    if (kl_next != 2'd3) begin
                        kl_next = kl_next + 2'd1;
                    end
                end
            end
        end

        if (data.is_last) begin
            if (kl_next != 2'd0) begin
                arr = (kl_next == 2'd3) && (h0_next == CH_LBR) && (h1_next == CH_RBR);
                if (!ivp_next && !arr) begin
                    res[n] = make_out(KIND_KEY, h0_next, 1'b0);
                    n      = n + 3'd1;
                    if (kl_next[1]) begin
                        res[n] = make_out(KIND_KEY, h1_next, 1'b0);
                        n      = n + 3'd1;
                    end
                end
                res[n] = make_out(KIND_COMMIT, 8'd0, arr);
                n      = n + 3'd1;
            end else begin
                res[n] = make_out(KIND_DISCARD, 8'd0, 1'b0);
                n      = n + 3'd1;
            end
            ivp_next = 1'b0;
            esc_next = ESC_IDLE;
            hn_next  = 4'd0;
            kl_next  = 2'd0;
        end

        if (n != '0) begin
            res[n - 3'd1].end_of_run = 1'b1;
        end
    end

    assign bundle.cnt = n;
    assign bundle.res = res;
    assign push       = accept && (n != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            esc_reg <= ESC_IDLE;
            ivp_reg <= 1'b0;
            hn_reg  <= 4'd0;
            kl_reg  <= 2'd0;
        end else if (accept) begin
            esc_reg <= esc_next;
            ivp_reg <= ivp_next;
            hn_reg  <= hn_next;
            kl_reg  <= kl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            h0_reg <= h0_next;
            h1_reg <= h1_next;
        end
    end

endmodule

[sv/fqd_queue.sv]
module fqd_queue
    import fqd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  fqd_bundle_t push_data,
    output logic        full,
    input  logic        pop,
    output logic        nonempty,
    output fqd_bundle_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    fqd_bundle_t       mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg;

    assign full     = (count_reg == CNT_QW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[sv/fqd_back.sv]
module fqd_back
    import fqd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        nonempty,
    input  fqd_bundle_t pop_data,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_stall,
    output fqd_out_t    result_data
);

    fqd_bundle_t      cur_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             busy_reg;
    logic             taken, done;

    assign result_valid = busy_reg;
    assign result_data  = cur_reg.res[idx_reg];
    assign taken        = busy_reg && !result_stall;
    assign done         = taken && (idx_reg == cur_reg.cnt - 3'd1);
    // next bundle loads as the last beat of the current one leaves
    assign pop          = nonempty && (!busy_reg || done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (done) begin
            busy_reg <= 1'b0;
        end else if (taken) begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            cur_reg <= pop_data;
        end
    end

endmodule
